// ----- sv/gps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types and constants of the path smoother: sizes, register indexes,
// controller states, datapath operations and the command and status groups.
// ----------------------------------------------------------------------------
package gps_pkg;

  localparam int MAX_POINTS    = 16;
  localparam int MAX_UP_SAMPLE = 4;
  localparam int WORK_DEPTH    = MAX_POINTS * MAX_UP_SAMPLE;
  localparam int PIDX_W        = $clog2(MAX_POINTS);
  localparam int CNT_W         = $clog2(MAX_POINTS + 1);
  localparam int WIDX_W        = $clog2(WORK_DEPTH);
  localparam int TOT_W         = $clog2(WORK_DEPTH + 1);

  localparam logic [18:0] WEIGHT_MAX = 19'd327679;
  localparam logic [31:0] SUM_MAX    = 32'hFFFF_FFFF;

  localparam logic [2:0] REG_TOLERANCE     = 3'd0;
  localparam logic [2:0] REG_DATA_WEIGHT   = 3'd1;
  localparam logic [2:0] REG_SMOOTH_WEIGHT = 3'd2;
  localparam logic [2:0] REG_UP_SAMPLE     = 3'd3;
  localparam logic [2:0] REG_MAX_ITER      = 3'd4;

  typedef struct packed {
    logic [31:0] tolerance;
    logic [18:0] data_weight;
    logic [18:0] smooth_weight;
    logic [2:0]  up_sample;
    logic [15:0] max_iterations;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_CHECK, ST_INIT, ST_PASS, ST_RD1, ST_RD2, ST_RD3, ST_RD4,
    ST_D1, ST_M1, ST_R1, ST_U1, ST_D2, ST_M2, ST_R2, ST_U2, ST_WB, ST_PEND,
    ST_OUT_RD, ST_OUT_LAT, ST_OUT_WAIT
  } state_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_INIT, OP_PASS, OP_RD1, OP_RD2, OP_RD3, OP_RD4,
    OP_D1, OP_D2, OP_MUL_D, OP_MUL_S, OP_RND, OP_UPD, OP_WB, OP_PEND,
    OP_OUT_RD, OP_OUT_LAT, OP_OUT_WAIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic short_path;
    logic init_last;
    logic wb_last;
    logic pass_done;
    logic out_done;
    logic out_last;
  } sts_t;

endpackage

// ----- sv/gps_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- sv/gps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_ctrl
// Sequencer of the smoother: loading, work store fill, smoothing passes and
// result delivery, issued to the datapath as one operation per cycle.
// ----------------------------------------------------------------------------
module gps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_end_of_path,
  output logic          in_stall,
  input  gps_pkg::sts_t sts,
  output gps_pkg::cmd_t cmd
);

  gps_pkg::state_t state_r, state_nxt;
  logic accept;

  assign in_stall = (state_r != gps_pkg::ST_LOAD);
  assign accept   = in_valid && (state_r == gps_pkg::ST_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gps_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gps_pkg::ST_LOAD:     if (accept && in_end_of_path) state_nxt = gps_pkg::ST_CHECK;
      gps_pkg::ST_CHECK:    state_nxt = sts.empty ? gps_pkg::ST_LOAD : gps_pkg::ST_INIT;
      gps_pkg::ST_INIT: begin
        if (sts.init_last) begin
          state_nxt = sts.short_path ? gps_pkg::ST_OUT_RD : gps_pkg::ST_PASS;
        end
      end
      gps_pkg::ST_PASS:     state_nxt = gps_pkg::ST_RD1;
      gps_pkg::ST_RD1:      state_nxt = gps_pkg::ST_RD2;
      gps_pkg::ST_RD2:      state_nxt = gps_pkg::ST_RD3;
      gps_pkg::ST_RD3:      state_nxt = gps_pkg::ST_RD4;
      gps_pkg::ST_RD4:      state_nxt = gps_pkg::ST_D1;
      gps_pkg::ST_D1:       state_nxt = gps_pkg::ST_M1;
      gps_pkg::ST_M1:       state_nxt = gps_pkg::ST_R1;
      gps_pkg::ST_R1:       state_nxt = gps_pkg::ST_U1;
      gps_pkg::ST_U1:       state_nxt = gps_pkg::ST_D2;
      gps_pkg::ST_D2:       state_nxt = gps_pkg::ST_M2;
      gps_pkg::ST_M2:       state_nxt = gps_pkg::ST_R2;
      gps_pkg::ST_R2:       state_nxt = gps_pkg::ST_U2;
      gps_pkg::ST_U2:       state_nxt = gps_pkg::ST_WB;
      gps_pkg::ST_WB:       state_nxt = sts.wb_last ? gps_pkg::ST_PEND : gps_pkg::ST_D1;
      gps_pkg::ST_PEND:     state_nxt = sts.pass_done ? gps_pkg::ST_OUT_RD : gps_pkg::ST_PASS;
      gps_pkg::ST_OUT_RD:   state_nxt = gps_pkg::ST_OUT_LAT;
      gps_pkg::ST_OUT_LAT:  state_nxt = gps_pkg::ST_OUT_WAIT;
      gps_pkg::ST_OUT_WAIT: begin
        if (sts.out_done) begin
          state_nxt = sts.out_last ? gps_pkg::ST_LOAD : gps_pkg::ST_OUT_RD;
        end
      end
      default:              state_nxt = gps_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd.op = gps_pkg::OP_IDLE;
    unique case (state_r)
      gps_pkg::ST_LOAD:     cmd.op = accept ? gps_pkg::OP_LOAD : gps_pkg::OP_IDLE;
      gps_pkg::ST_CHECK:    cmd.op = gps_pkg::OP_IDLE;
      gps_pkg::ST_INIT:     cmd.op = gps_pkg::OP_INIT;
      gps_pkg::ST_PASS:     cmd.op = gps_pkg::OP_PASS;
      gps_pkg::ST_RD1:      cmd.op = gps_pkg::OP_RD1;
      gps_pkg::ST_RD2:      cmd.op = gps_pkg::OP_RD2;
      gps_pkg::ST_RD3:      cmd.op = gps_pkg::OP_RD3;
      gps_pkg::ST_RD4:      cmd.op = gps_pkg::OP_RD4;
      gps_pkg::ST_D1:       cmd.op = gps_pkg::OP_D1;
      gps_pkg::ST_M1:       cmd.op = gps_pkg::OP_MUL_D;
      gps_pkg::ST_R1:       cmd.op = gps_pkg::OP_RND;
      gps_pkg::ST_U1:       cmd.op = gps_pkg::OP_UPD;
      gps_pkg::ST_D2:       cmd.op = gps_pkg::OP_D2;
      gps_pkg::ST_M2:       cmd.op = gps_pkg::OP_MUL_S;
      gps_pkg::ST_R2:       cmd.op = gps_pkg::OP_RND;
      gps_pkg::ST_U2:       cmd.op = gps_pkg::OP_UPD;
      gps_pkg::ST_WB:       cmd.op = gps_pkg::OP_WB;
      gps_pkg::ST_PEND:     cmd.op = gps_pkg::OP_PEND;
      gps_pkg::ST_OUT_RD:   cmd.op = gps_pkg::OP_OUT_RD;
      gps_pkg::ST_OUT_LAT:  cmd.op = gps_pkg::OP_OUT_LAT;
      gps_pkg::ST_OUT_WAIT: cmd.op = gps_pkg::OP_OUT_WAIT;
      default:              cmd.op = gps_pkg::OP_IDLE;
    endcase
  end

  // The point sequence always leaves write-back for the next point or the
  // pass decision.
  a_wb_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gps_pkg::ST_WB |=> state_r == gps_pkg::ST_D1 || state_r == gps_pkg::ST_PEND)
    else $error("write-back not followed by next point or pass end");

  // A held result keeps the controller waiting.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gps_pkg::ST_OUT_WAIT && !sts.out_done |=> state_r == gps_pkg::ST_OUT_WAIT)
    else $error("left result wait before the transaction completed");

  // A pass only starts with a path of at least three stored points.
  a_pass_path: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gps_pkg::ST_PASS |-> !sts.short_path && !sts.empty)
    else $error("smoothing pass started on a short path");

endmodule

// ----- sv/gps_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_dp
// Datapath of the smoother: point store, work store RAM, neighbor window,
// weighted step arithmetic, change sum, pass counter and result register.
// ----------------------------------------------------------------------------
module gps_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  gps_pkg::cmd_t       cmd,
  output gps_pkg::sts_t       sts,
  input  gps_pkg::cfg_t       cfg,
  input  logic signed [31:0]  in_point_x,
  input  logic signed [31:0]  in_point_y,
  input  logic                in_end_of_path,
  input  logic                out_stall,
  output logic                out_valid,
  output logic signed [31:0]  out_smooth_x,
  output logic signed [31:0]  out_smooth_y,
  output logic                out_last_point
);

  localparam int PW = gps_pkg::PIDX_W;
  localparam int CW = gps_pkg::CNT_W;
  localparam int WW = gps_pkg::WIDX_W;
  localparam int TW = gps_pkg::TOT_W;

  logic signed [31:0] orig_x_r [gps_pkg::MAX_POINTS];
  logic signed [31:0] orig_y_r [gps_pkg::MAX_POINTS];
  logic [CW-1:0] cnt_r;
  logic [TW-1:0] total_r, j_r;
  logic [2:0]    ups_r, s_r;
  logic [PW-1:0] k_r;
  logic          short_r, out_valid_r, out_last_r;
  logic signed [31:0] prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic signed [31:0] nxt_x_r, nxt_y_r, pend_x_r, pend_y_r;
  logic signed [33:0] diff_x_r, diff_y_r;
  logic signed [53:0] prod_x_r, prod_y_r;
  logic signed [39:0] d_x_r, d_y_r;
  logic [39:0]        mag_x_r, mag_y_r;
  logic [63:0]        sq_x_r, sq_y_r;
  logic               big_x_r, big_y_r;
  logic [31:0]        sum_r, sum_nxt;
  logic [16:0]        pass_r;
  logic signed [31:0] out_x_r, out_y_r;

  logic [18:0]   dw, sw, wsel;
  logic [2:0]    ups_eff, ups_run;
  logic [15:0]   lim;
  logic [CW-1:0] n_pts;
  logic          we;
  logic [WW-1:0] raddr, waddr;
  logic [63:0]   wdata, rdata;
  logic [31:0]   term_x, term_y;
  logic [33:0]   acc;
  logic signed [31:0] cur_x_nxt, cur_y_nxt;
  logic signed [39:0] rnd_x, rnd_y;
  logic          s_wrap;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] res;
    if (v > 41'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -41'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] sq_term(input logic [63:0] sq, input logic big);
    logic [48:0] r;
    r = {1'b0, sq[63:16]} + 49'(sq[15]);
    return (big || (|r[48:32])) ? gps_pkg::SUM_MAX : r[31:0];
  endfunction

  assign dw   = (cfg.data_weight > gps_pkg::WEIGHT_MAX) ? gps_pkg::WEIGHT_MAX
                                                        : cfg.data_weight;
  assign sw   = (cfg.smooth_weight > gps_pkg::WEIGHT_MAX) ? gps_pkg::WEIGHT_MAX
                                                          : cfg.smooth_weight;
  assign wsel = (cmd.op == gps_pkg::OP_MUL_D) ? dw : sw;
  assign lim  = (cfg.max_iterations == 16'd0) ? 16'd1 : cfg.max_iterations;

  always_comb begin
    if (cfg.up_sample == 3'd0) begin
      ups_eff = 3'd1;
    end else if (cfg.up_sample > 3'(gps_pkg::MAX_UP_SAMPLE)) begin
      ups_eff = 3'(gps_pkg::MAX_UP_SAMPLE);
    end else begin
      ups_eff = cfg.up_sample;
    end
  end

  // Stored count after this point, with a full store dropping the point.
  assign n_pts   = (cnt_r < CW'(gps_pkg::MAX_POINTS)) ? cnt_r + CW'(1) : cnt_r;
  assign ups_run = (n_pts <= CW'(2)) ? 3'd1 : ups_eff;
  assign s_wrap  = (s_r == ups_r - 3'd1);

  assign term_x  = sq_term(sq_x_r, big_x_r);
  assign term_y  = sq_term(sq_y_r, big_y_r);
  assign acc     = {2'b00, sum_r} + {2'b00, term_x} + {2'b00, term_y};
  assign sum_nxt = (|acc[33:32]) ? gps_pkg::SUM_MAX : acc[31:0];

  assign cur_x_nxt = sat32({{9{cur_x_r[31]}}, cur_x_r} + {d_x_r[39], d_x_r});
  assign cur_y_nxt = sat32({{9{cur_y_r[31]}}, cur_y_r} + {d_y_r[39], d_y_r});

  // Round to nearest with ties upward is a floor after adding one half.
  assign rnd_x = 40'($signed(prod_x_r[53:16])) + 40'(prod_x_r[15]);
  assign rnd_y = 40'($signed(prod_y_r[53:16])) + 40'(prod_y_r[15]);

  always_comb begin
    raddr = j_r[WW-1:0];
    unique case (cmd.op)
      gps_pkg::OP_RD1:  raddr = WW'(0);
      gps_pkg::OP_RD2:  raddr = WW'(1);
      gps_pkg::OP_RD3:  raddr = WW'(2);
      gps_pkg::OP_D1:   raddr = WW'(j_r + TW'(2));
      default:          raddr = j_r[WW-1:0];
    endcase
  end

  assign we    = (cmd.op == gps_pkg::OP_INIT) || (cmd.op == gps_pkg::OP_WB);
  assign waddr = j_r[WW-1:0];
  assign wdata = (cmd.op == gps_pkg::OP_INIT) ? {orig_y_r[k_r], orig_x_r[k_r]}
                                              : {cur_y_r, cur_x_r};

  gps_ram #(.WIDTH(64), .DEPTH(gps_pkg::WORK_DEPTH)) u_work (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      case (cmd.op)
        gps_pkg::OP_LOAD: begin
          cnt_r <= in_end_of_path ? '0 : n_pts;
          if (in_end_of_path) begin
            total_r <= TW'(n_pts) * TW'(ups_run);
          end
        end
        gps_pkg::OP_OUT_LAT:  out_valid_r <= 1'b1;
        gps_pkg::OP_OUT_WAIT: if (!out_stall) out_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      gps_pkg::OP_LOAD: begin
        if (cnt_r < CW'(gps_pkg::MAX_POINTS)) begin
          orig_x_r[cnt_r[PW-1:0]] <= in_point_x;
          orig_y_r[cnt_r[PW-1:0]] <= in_point_y;
        end
        ups_r   <= ups_run;
        short_r <= (n_pts <= CW'(2));
        j_r     <= '0;
        k_r     <= '0;
        s_r     <= '0;
      end
      gps_pkg::OP_INIT: begin
        j_r <= (j_r == total_r - TW'(1)) ? '0 : j_r + TW'(1);
        s_r <= s_wrap ? 3'd0 : s_r + 3'd1;
        if (s_wrap) k_r <= k_r + PW'(1);
      end
      gps_pkg::OP_PASS: begin
        sum_r <= '0;
        j_r   <= TW'(1);
        k_r   <= (ups_r == 3'd1) ? PW'(1) : PW'(0);
        s_r   <= (ups_r == 3'd1) ? 3'd0 : 3'd1;
      end
      gps_pkg::OP_RD2: begin
        prev_x_r <= rdata[31:0];
        prev_y_r <= rdata[63:32];
      end
      gps_pkg::OP_RD3: begin
        cur_x_r <= rdata[31:0];
        cur_y_r <= rdata[63:32];
      end
      gps_pkg::OP_RD4: begin
        nxt_x_r <= rdata[31:0];
        nxt_y_r <= rdata[63:32];
      end
      gps_pkg::OP_D1: begin
        diff_x_r <= 34'(orig_x_r[k_r]) - 34'(cur_x_r);
        diff_y_r <= 34'(orig_y_r[k_r]) - 34'(cur_y_r);
      end
      gps_pkg::OP_D2: begin
        sum_r    <= sum_nxt;
        diff_x_r <= 34'(prev_x_r) + 34'(nxt_x_r) - (34'(cur_x_r) <<< 1);
        diff_y_r <= 34'(prev_y_r) + 34'(nxt_y_r) - (34'(cur_y_r) <<< 1);
      end
      gps_pkg::OP_MUL_D, gps_pkg::OP_MUL_S: begin
        prod_x_r <= diff_x_r * $signed({1'b0, wsel});
        prod_y_r <= diff_y_r * $signed({1'b0, wsel});
        if (cmd.op == gps_pkg::OP_MUL_D) begin
          pend_x_r <= rdata[31:0];
          pend_y_r <= rdata[63:32];
        end
      end
      gps_pkg::OP_RND: begin
        d_x_r   <= rnd_x;
        d_y_r   <= rnd_y;
        mag_x_r <= rnd_x[39] ? -rnd_x : rnd_x;
        mag_y_r <= rnd_y[39] ? -rnd_y : rnd_y;
      end
      gps_pkg::OP_UPD: begin
        cur_x_r <= cur_x_nxt;
        cur_y_r <= cur_y_nxt;
        sq_x_r  <= mag_x_r[31:0] * mag_x_r[31:0];
        sq_y_r  <= mag_y_r[31:0] * mag_y_r[31:0];
        big_x_r <= |mag_x_r[39:32];
        big_y_r <= |mag_y_r[39:32];
      end
      gps_pkg::OP_WB: begin
        sum_r    <= sum_nxt;
        prev_x_r <= cur_x_r;
        prev_y_r <= cur_y_r;
        cur_x_r  <= nxt_x_r;
        cur_y_r  <= nxt_y_r;
        nxt_x_r  <= pend_x_r;
        nxt_y_r  <= pend_y_r;
        j_r      <= j_r + TW'(1);
        s_r      <= s_wrap ? 3'd0 : s_r + 3'd1;
        if (s_wrap) k_r <= k_r + PW'(1);
      end
      gps_pkg::OP_PEND: begin
        pass_r <= pass_r + 17'd1;
        j_r    <= '0;
      end
      gps_pkg::OP_OUT_LAT: begin
        out_x_r    <= rdata[31:0];
        out_y_r    <= rdata[63:32];
        out_last_r <= (j_r == total_r - TW'(1));
      end
      gps_pkg::OP_OUT_WAIT: begin
        if (!out_stall) j_r <= j_r + TW'(1);
      end
      default: ;
    endcase
    if (cmd.op == gps_pkg::OP_INIT && !short_r && j_r == total_r - TW'(1)) begin
      pass_r <= '0;
    end
  end

  assign sts.empty      = (total_r == '0);
  assign sts.short_path = short_r;
  assign sts.init_last  = (j_r == total_r - TW'(1));
  assign sts.wb_last    = (TW'(j_r + TW'(2)) == total_r);
  assign sts.pass_done  = (pass_r > {1'b0, lim}) || (sum_r < cfg.tolerance);
  assign sts.out_done   = out_valid_r && !out_stall;
  assign sts.out_last   = out_last_r;

  assign out_valid      = out_valid_r;
  assign out_smooth_x   = out_x_r;
  assign out_smooth_y   = out_y_r;
  assign out_last_point = out_last_r;

endmodule

// ----- sv/gradient_path_smoother.sv -----
`timescale 1ns / 1ps
// Sequence: points are loaded into the store, the work store is filled, the smoothing
// passes run over the inner points, and each result is read out and held until the
// receiver takes it. One path is handled at a time; the single shared step datapath
// visits the inner points one after another, and the input stalls until the path is out.
// Reset (rst_n low, synchronous) empties the point store, idles the sequencer and
// loads the register defaults; the work RAM is not cleared.
// ----------------------------------------------------------------------------
// gradient_path_smoother
// Top level: APB-style register block, sequencer and smoothing datapath.
// ----------------------------------------------------------------------------
module gradient_path_smoother (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic               in_end_of_path,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_smooth_x,
  output logic signed [31:0] out_smooth_y,
  output logic               out_last_point,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  gps_pkg::cfg_t cfg_r;
  gps_pkg::cmd_t cmd;
  gps_pkg::sts_t sts;
  logic          wr_en;

  // A write transaction lands on the access cycle; registers are word spaced.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tolerance      <= 32'd66;
      cfg_r.data_weight    <= 19'd32768;
      cfg_r.smooth_weight  <= 19'd6554;
      cfg_r.up_sample      <= 3'd1;
      cfg_r.max_iterations <= 16'd1000;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        gps_pkg::REG_TOLERANCE:     cfg_r.tolerance      <= pwdata;
        gps_pkg::REG_DATA_WEIGHT:   cfg_r.data_weight    <= pwdata[18:0];
        gps_pkg::REG_SMOOTH_WEIGHT: cfg_r.smooth_weight  <= pwdata[18:0];
        gps_pkg::REG_UP_SAMPLE:     cfg_r.up_sample      <= pwdata[2:0];
        gps_pkg::REG_MAX_ITER:      cfg_r.max_iterations <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Reads return the stored value, zero extended; unused indexes read zero.
  always_comb begin
    unique case (paddr[4:2])
      gps_pkg::REG_TOLERANCE:     prdata = cfg_r.tolerance;
      gps_pkg::REG_DATA_WEIGHT:   prdata = 32'(cfg_r.data_weight);
      gps_pkg::REG_SMOOTH_WEIGHT: prdata = 32'(cfg_r.smooth_weight);
      gps_pkg::REG_UP_SAMPLE:     prdata = 32'(cfg_r.up_sample);
      gps_pkg::REG_MAX_ITER:      prdata = 32'(cfg_r.max_iterations);
      default:                    prdata = '0;
    endcase
  end

  // The sequencer owns the input handshake and steps the datapath.
  gps_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_end_of_path (in_end_of_path),
    .in_stall       (in_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  // The datapath holds all points and drives the result transaction.
  gps_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg            (cfg_r),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_end_of_path (in_end_of_path),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_smooth_x   (out_smooth_x),
    .out_smooth_y   (out_smooth_y),
    .out_last_point (out_last_point)
  );

endmodule

// ----- tb/sv/tb_gradient_path_smoother.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_path_smoother
// Self-checking bench for the path smoother. Waypoint paths are driven through
// the valid/stall input channel while a local fixed-point model of the
// smoothing passes predicts every smoothed point. The output monitor compares
// each result transaction with the oldest prediction. Registers are written
// over the APB-style port between phases, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_gradient_path_smoother;

  // Index of an unmapped register; a write to it must be ignored.
  localparam logic [2:0] REG_UNMAPPED = 3'd5;
  localparam int         RUN_LIMIT    = 4000000;
  localparam int         DRAIN_CYCLES = 60;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               eop;
  } waypoint_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } smooth_pt_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_point_x;
  logic signed [31:0] in_point_y;
  logic               in_end_of_path;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_smooth_x;
  logic signed [31:0] out_smooth_y;
  logic               out_last_point;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  gradient_path_smoother dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_end_of_path (in_end_of_path),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_smooth_x   (out_smooth_x),
    .out_smooth_y   (out_smooth_y),
    .out_last_point (out_last_point),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Waypoints waiting to be offered, and smoothed points still to arrive.
  waypoint_t  waypoint_queue[$];
  smooth_pt_t smooth_expected[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_request;
  int  mismatch_count;
  int  cycle_count;
  bit  in_taken;

  // Local copy of the register file.
  logic [31:0] m_tolerance;
  logic [18:0] m_data_weight;
  logic [18:0] m_smooth_weight;
  logic [2:0]  m_up_sample;
  logic [15:0] m_max_iter;

  // Local copy of the point store and the working points.
  longint      stored_x[gps_pkg::MAX_POINTS];
  longint      stored_y[gps_pkg::MAX_POINTS];
  longint      track_x[gps_pkg::WORK_DEPTH];
  longint      track_y[gps_pkg::WORK_DEPTH];
  int          stored_count;
  logic [31:0] pass_sum;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Squared move in Q16.16, rounded half up and saturated.
  function automatic logic [31:0] squared_move(longint d);
    longint unsigned m;
    longint unsigned sq;
    longint unsigned r;
    m = (d < 0) ? longint'(-d) : longint'(d);
    if (m >= 64'h1_0000_0000) return gps_pkg::SUM_MAX;
    sq = m * m;
    r = (sq >> 16) + ((sq >> 15) & 64'd1);
    if (r > 64'hFFFF_FFFF) return gps_pkg::SUM_MAX;
    return r[31:0];
  endfunction

  // One weighted pull of one coordinate; adds its squared move to pass_sum.
  function automatic longint nudge(longint cur, longint diff, longint w);
    longint     d;
    logic [32:0] s;
    // Rounding to nearest with ties upward is a floor of the value plus half.
    d = (diff * w + 64'sd32768) >>> 16;
    s = {1'b0, pass_sum} + {1'b0, squared_move(d)};
    pass_sum = s[32] ? gps_pkg::SUM_MAX : s[31:0];
    return clamp32(cur + d);
  endfunction

  task automatic smooth_track(int total, int ups);
    longint dw;
    longint sw;
    int     lim;
    int     passes;
    int     k;
    bit     stop;
    bit     done;
    dw = (m_data_weight > gps_pkg::WEIGHT_MAX) ? gps_pkg::WEIGHT_MAX : m_data_weight;
    sw = (m_smooth_weight > gps_pkg::WEIGHT_MAX) ? gps_pkg::WEIGHT_MAX : m_smooth_weight;
    lim = (m_max_iter == 16'd0) ? 1 : m_max_iter;
    passes = 0;
    done = 1'b0;
    while (!done) begin
      pass_sum = '0;
      for (int i = 1; i + 1 < total; i++) begin
        k = i / ups;
        track_x[i] = nudge(track_x[i], stored_x[k] - track_x[i], dw);
        track_y[i] = nudge(track_y[i], stored_y[k] - track_y[i], dw);
        track_x[i] = nudge(track_x[i], track_x[i-1] + track_x[i+1] - 2 * track_x[i], sw);
        track_y[i] = nudge(track_y[i], track_y[i-1] + track_y[i+1] - 2 * track_y[i], sw);
      end
      stop = passes > lim;
      passes++;
      done = stop || (pass_sum < m_tolerance);
    end
  endtask

  // Stores one accepted waypoint and, on the end of a path, queues the
  // smoothed points that the run produces.
  task automatic predict_waypoint(logic signed [31:0] px, logic signed [31:0] py, logic eop);
    int         n;
    int         ups;
    int         total;
    smooth_pt_t pt;
    if (stored_count < gps_pkg::MAX_POINTS) begin
      stored_x[stored_count] = px;
      stored_y[stored_count] = py;
      stored_count++;
    end
    if (!eop) return;
    n = stored_count;
    stored_count = 0;
    if (n == 0) return;
    if (n <= 2) begin
      ups = 1;
      total = n;
    end else begin
      ups = (m_up_sample == 3'd0) ? 1 : m_up_sample;
      if (ups > gps_pkg::MAX_UP_SAMPLE) ups = gps_pkg::MAX_UP_SAMPLE;
      total = n * ups;
    end
    for (int i = 0; i < total; i++) begin
      track_x[i] = stored_x[i / ups];
      track_y[i] = stored_y[i / ups];
    end
    if (n > 2) smooth_track(total, ups);
    for (int i = 0; i < total; i++) begin
      pt.x = track_x[i][31:0];
      pt.y = track_y[i][31:0];
      pt.last = (i + 1 == total);
      smooth_expected = {smooth_expected, pt};
    end
  endtask

  // Input side: a transaction is recorded at the edge where it is accepted.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    in_taken <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      predict_waypoint(in_point_x, in_point_y, in_end_of_path);
    end
  end

  // Output monitor: every result transaction is checked against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    smooth_pt_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (smooth_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected result x=%h y=%h last=%b",
                   out_smooth_x, out_smooth_y, out_last_point);
        end
      end else begin
        want = smooth_expected.pop_front();
        if (out_smooth_x !== want.x || out_smooth_y !== want.y ||
            out_last_point !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
                     want.x, want.y, want.last,
                     out_smooth_x, out_smooth_y, out_last_point);
          end
        end
      end
    end
  end

  // Input driver: a new waypoint is offered only once the previous one has
  // gone through, so a stalled transaction never changes.
  always @(negedge clk) begin
    waypoint_t wp;
    if (rst_n && (!in_valid || in_taken)) begin
      if (waypoint_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        wp = waypoint_queue.pop_front();
        in_point_x     <= wp.x;
        in_point_y     <= wp.y;
        in_end_of_path <= wp.eop;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall driver. A hold-off request keeps the receiver stalled until it
  // counts down, so the block backs up and stalls its input in turn.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      out_stall <= 1'b1;
      hold_request <= hold_request - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      gps_pkg::REG_TOLERANCE:     m_tolerance     = value;
      gps_pkg::REG_DATA_WEIGHT:   m_data_weight   = value[18:0];
      gps_pkg::REG_SMOOTH_WEIGHT: m_smooth_weight = value[18:0];
      gps_pkg::REG_UP_SAMPLE:     m_up_sample     = value[2:0];
      gps_pkg::REG_MAX_ITER:      m_max_iter      = value[15:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [31:0] tol, logic [18:0] dw, logic [18:0] sw,
                              logic [2:0] ups, logic [15:0] iters);
    write_reg(gps_pkg::REG_TOLERANCE, tol);
    write_reg(gps_pkg::REG_DATA_WEIGHT, {13'd0, dw});
    write_reg(gps_pkg::REG_SMOOTH_WEIGHT, {13'd0, sw});
    write_reg(gps_pkg::REG_UP_SAMPLE, {29'd0, ups});
    write_reg(gps_pkg::REG_MAX_ITER, {16'd0, iters});
  endtask

  task automatic queue_point(logic signed [31:0] x, logic signed [31:0] y, logic eop);
    waypoint_t wp;
    wp.x = x;
    wp.y = y;
    wp.eop = eop;
    waypoint_queue = {waypoint_queue, wp};
  endtask

  // Waits until every waypoint is taken and every result has come back,
  // then lets the block settle before registers may change.
  task automatic wait_idle();
    while (waypoint_queue.size() > 0 || in_valid || smooth_expected.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random paths: mostly short, now and then as long as the store or longer.
  // Narrow coordinates keep diverging weights from pinning every move.
  task automatic queue_random_paths(int count, bit narrow);
    int len;
    int sent;
    logic signed [31:0] x;
    logic signed [31:0] y;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0)
            ? $urandom_range(gps_pkg::MAX_POINTS, gps_pkg::MAX_POINTS + 3)
            : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        x = $urandom;
        y = $urandom;
        if (narrow) begin
          x = x >>> 12;
          y = y >>> 12;
        end
        queue_point(x, y, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_point_x     = '0;
    in_point_y     = '0;
    in_end_of_path = 1'b0;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_request   = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    in_taken       = 1'b0;
    stored_count   = 0;
    pass_sum       = '0;
    // Register defaults after reset.
    m_tolerance     = 32'd66;
    m_data_weight   = 19'd32768;
    m_smooth_weight = 19'd6554;
    m_up_sample     = 3'd1;
    m_max_iter      = 16'd1000;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed paths under the reset settings: a single point and a pair of
    // points come back unchanged, a three-point path is smoothed.
    send_idle_pct = 31;
    recv_idle_pct = 82;
    queue_point(32'sh7FFF_FFFF, -32'sh8000_0000, 1'b1);
    queue_point(-32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    queue_point(32'sh7FFF_FFFF, -32'sh8000_0000, 1'b1);
    queue_point(32'sh0001_0000, 32'sh0000_0000, 1'b0);
    queue_point(32'sh0005_0000, 32'sh0003_0000, 1'b0);
    queue_point(32'sh0002_0000, -32'sh0004_0000, 1'b1);
    wait_idle();

    // Weights of five or more saturate to just under five, up_sample above the limit saturates,
    // a zero pass limit counts as one and zero tolerance never converges.
    // Alternating rails drive the positions and the change sum to saturation.
    program_regs(32'd0, 19'h7FFFF, 19'h7FFFF, 3'd7, 16'd0);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    queue_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    queue_point(-32'sh8000_0000, -32'sh8000_0000, 1'b0);
    queue_point(32'sh7FFF_FFFF, -32'sh8000_0000, 1'b0);
    queue_point(-32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    wait_idle();

    // Zero weights and a zero up_sample, with a pass limit of one.
    program_regs(32'hFFFF_FFFF, 19'd0, 19'd0, 3'd0, 16'd1);
    queue_point(32'sh1234_5678, -32'sh0765_4321, 1'b0);
    queue_point(32'sh0000_0001, 32'sh0000_0000, 1'b0);
    queue_point(-32'sh0000_0001, 32'sh7FFF_FFFF, 1'b1);
    wait_idle();

    // Largest pass limit; the huge tolerance stops the run after one pass.
    program_regs(32'hFFFF_FFFF, 19'd32768, 19'd6554, 3'd4, 16'hFFFF);
    queue_point(32'sh0001_0000, 32'sh0001_0000, 1'b0);
    queue_point(32'sh0003_0000, -32'sh0002_0000, 1'b0);
    queue_point(32'sh0000_8000, 32'sh0004_0000, 1'b0);
    queue_point(-32'sh0001_0000, 32'sh0000_0000, 1'b1);
    wait_idle();

    // Random phases, each under fresh register settings and a pass limit
    // small enough to keep the long paths quick.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 31;
        recv_idle_pct = 82;
      end else if (phase < 4) begin
        send_idle_pct = 82;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(3))
        0: m_tolerance = 32'd0;
        1: m_tolerance = $urandom_range(1, 5000);
        2: m_tolerance = 32'hFFFF_FFFF;
        default: m_tolerance = $urandom;
      endcase
      program_regs(m_tolerance, 19'($urandom_range(0, 19'h7FFFF)),
                   19'($urandom_range(0, 19'h7FFFF)),
                   3'($urandom_range(0, 7)), 16'($urandom_range(0, 10)));
      // The receiver holds off for a long stretch while waypoints keep coming.
      if (phase == 4) hold_request = 3000;
      queue_random_paths(75, phase[0]);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
